### src/fahq_pkg.sv
// Shared types and codes for the four-ary min-heap queue.
package fahq_pkg;

  // Heap store depth; slot_index and entry_count are sized for it.
  localparam int MAX_ENTRIES = 256;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_APPEND  = 3'd1;
  localparam logic [2:0] OP_HEAPIFY = 3'd2;
  localparam logic [2:0] OP_EXTRACT = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;
  localparam logic [2:0] OP_UPDATE  = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_UNORD   = 3'd3;
  localparam logic [2:0] ST_BADIDX  = 3'd4;

  localparam logic [0:0] REG_CAPACITY = 1'd0;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] member_tag;
    logic [63:0] priority_req;
    logic [7:0]  slot_index;
  } fahq_in_t;

  typedef struct packed {
    logic [15:0] out_member;
    logic [63:0] out_priority;
    logic        out_valid;
    logic [2:0]  status;
    logic [8:0]  entry_count;
    logic        ordered_flag;
  } fahq_out_t;

endpackage

### src/four_ary_min_heap_queue_top.sv
// Top level of the four-ary min-heap queue: sequencer, heap memory and ports.
//
// Each transfer carries one operation and yields exactly one result transfer.
// The block works on one item at a time and drops in_ready while busy. The
// heap memory has one read port and one write port, and 64-bit priority
// compares act on its registered read data: a sift-up reads and then compares
// the parent for each level climbed, a sift-down issues its reads, folds up to
// four children into a minimum and then decides on a move for each level;
// heapify runs a sift-down from every slot, from the last slot down to slot 0.
// Append, clear and refused operations finish without any sift. The
// result sits in an output register until taken, so the next item may start
// meanwhile; capacity_limit is written at address 0 and read back at every
// address.
module four_ary_min_heap_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fahq_pkg::fahq_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fahq_pkg::fahq_out_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import fahq_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPRD   = 4'd1;  // read parent
  localparam logic [3:0] S_UPCMP  = 4'd2;  // compare parent
  localparam logic [3:0] S_DNRD   = 4'd3;  // read next child
  localparam logic [3:0] S_DNCMP  = 4'd4;  // fold child into minimum
  localparam logic [3:0] S_DNMOVE = 4'd5;  // decide on move
  localparam logic [3:0] S_LDRD   = 4'd6;  // read helper slot
  localparam logic [3:0] S_LDWT   = 4'd7;  // capture helper slot
  localparam logic [3:0] S_DONE   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Loader purposes.
  localparam logic [1:0] L_EXROOT = 2'd0;
  localparam logic [1:0] L_LAST   = 2'd1;
  localparam logic [1:0] L_SLOT   = 2'd2;
  localparam logic [1:0] L_HEAP   = 2'd3;

  logic [63:0] pri_mem [MAX_ENTRIES];
  logic [15:0] mem_mem [MAX_ENTRIES];

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic        ord_r, ord_nxt;
  logic [8:0]  cap_r;
  logic        out_v_r;
  fahq_out_t   res_r, res_nxt;
  fahq_out_t   res_hold_r;             // result waiting for its transfer
  fahq_in_t    req_r;

  logic [AW-1:0] x_r, x_nxt;           // hole position
  logic [63:0] kp_r, kp_nxt;           // key being placed
  logic [15:0] km_r, km_nxt;
  logic [AW-1:0] rd_addr;
  logic [63:0] rd_pri;
  logic [15:0] rd_mem;
  logic        we;
  logic [AW-1:0] wr_addr;
  logic [63:0] wr_pri;
  logic [15:0] wr_mem;

  logic [CW+2:0] ck_r, ck_nxt;         // child under scan
  logic [CW+2:0] clast_r, clast_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [63:0] bp_r, bp_nxt;
  logic [15:0] bm_r, bm_nxt;
  logic        have_r, have_nxt;
  logic [1:0]  lp_r, lp_nxt;
  logic [CW-1:0] hi_r, hi_nxt;         // heapify slot counter
  logic        hmode_r, hmode_nxt;

  logic [CW-1:0] room;
  logic [CW+2:0] first_c;
  logic [CW-1:0] fill_m1;

  // Memory: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      pri_mem[wr_addr] <= wr_pri;
      mem_mem[wr_addr] <= wr_mem;
    end
    rd_pri <= pri_mem[rd_addr];
    rd_mem <= mem_mem[rd_addr];
  end

  assign room    = (cap_r > 9'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_r);
  assign fill_m1 = fill_r - 1'b1;
  assign first_c = {x_r, 2'b00} + (CW+3)'(1);

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_v_r;
  assign out_data   = res_hold_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {23'd0, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_CAPACITY && cfg_paddr[1:0] == 2'd0) begin
      cap_r <= cfg_pwdata[8:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ord_nxt   = ord_r;
    res_nxt   = res_r;
    x_nxt     = x_r;
    kp_nxt    = kp_r;
    km_nxt    = km_r;
    ck_nxt    = ck_r;
    clast_nxt = clast_r;
    best_nxt  = best_r;
    bp_nxt    = bp_r;
    bm_nxt    = bm_r;
    have_nxt  = have_r;
    lp_nxt    = lp_r;
    hi_nxt    = hi_r;
    hmode_nxt = hmode_r;
    rd_addr   = x_r;
    we        = 1'b0;
    wr_addr   = x_r;
    wr_pri    = kp_r;
    wr_mem    = km_r;
    case (state_r)
      S_IDLE: begin
        res_nxt = '0;
        hmode_nxt = 1'b0;
        if (in_valid) begin
          case (in_data.operation)
            OP_INSERT: begin
              if (!ord_r) res_nxt.status = ST_UNORD;
              else if (fill_r >= room) res_nxt.status = ST_FULL;
              else begin
                fill_nxt = fill_r + 1'b1;
                x_nxt  = fill_r[AW-1:0];
                kp_nxt = in_data.priority_req;
                km_nxt = in_data.member_tag;
                state_nxt = S_UPRD;
              end
            end
            OP_APPEND: begin
              if (fill_r >= room) res_nxt.status = ST_FULL;
              else begin
                we = 1'b1;
                wr_addr = fill_r[AW-1:0];
                wr_pri = in_data.priority_req;
                wr_mem = in_data.member_tag;
                if (fill_r != '0) ord_nxt = 1'b0;
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_HEAPIFY: begin
              ord_nxt = 1'b1;
              if (fill_r != '0) begin
                hmode_nxt = 1'b1;
                hi_nxt = fill_m1;
                lp_nxt = L_HEAP;
                state_nxt = S_LDRD;
              end
            end
            OP_EXTRACT: begin
              if (!ord_r) res_nxt.status = ST_UNORD;
              else if (fill_r == '0) res_nxt.status = ST_EMPTY;
              else begin
                lp_nxt = L_EXROOT;
                state_nxt = S_LDRD;
              end
            end
            OP_REMOVE: begin
              if (!ord_r) res_nxt.status = ST_UNORD;
              else if (fill_r == '0) res_nxt.status = ST_EMPTY;
              else if (CW'(in_data.slot_index) >= fill_r) res_nxt.status = ST_BADIDX;
              else begin
                fill_nxt = fill_m1;
                if (CW'(in_data.slot_index) < fill_m1) begin
                  lp_nxt = L_LAST;
                  state_nxt = S_LDRD;
                end
              end
            end
            OP_UPDATE: begin
              if (CW'(in_data.slot_index) >= fill_r) res_nxt.status = ST_BADIDX;
              else if (!ord_r) res_nxt.status = ST_UNORD;
              else begin
                kp_nxt = in_data.priority_req;
                lp_nxt = L_SLOT;
                state_nxt = S_LDRD;
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
              ord_nxt  = 1'b1;
            end
            default: ;
          endcase
          if (state_nxt == S_IDLE) state_nxt = S_DONE;
        end
      end
      S_LDRD: begin
        case (lp_r)
          L_EXROOT: rd_addr = '0;
          L_LAST:   rd_addr = fill_r[AW-1:0];   // fill already decremented
          L_SLOT:   rd_addr = req_r.slot_index[AW-1:0];
          default:  rd_addr = hi_r[AW-1:0];
        endcase
        state_nxt = S_LDWT;
      end
      S_LDWT: begin
        case (lp_r)
          L_EXROOT: begin
            res_nxt.out_member   = rd_mem;
            res_nxt.out_priority = rd_pri;
            res_nxt.out_valid    = 1'b1;
            fill_nxt = fill_m1;
            if (fill_m1 == '0) state_nxt = S_DONE;
            else begin
              lp_nxt = L_LAST;
              state_nxt = S_LDRD;
            end
          end
          L_LAST: begin
            // Last entry fills the hole at the root or the removed slot.
            kp_nxt = rd_pri;
            km_nxt = rd_mem;
            x_nxt  = (req_r.operation == OP_EXTRACT) ? '0 : req_r.slot_index[AW-1:0];
            if (req_r.operation == OP_EXTRACT) begin
              state_nxt = S_DNRD;
              have_nxt = 1'b0;
            end else begin
              // Compare against the removed slot next.
              lp_nxt = L_SLOT;
              state_nxt = S_LDRD;
            end
          end
          L_SLOT: begin
            km_nxt = (req_r.operation == OP_UPDATE) ? rd_mem : km_r;
            x_nxt  = req_r.slot_index[AW-1:0];
            have_nxt = 1'b0;
            state_nxt = (kp_r <= rd_pri) ? S_UPRD : S_DNRD;
          end
          default: begin
            kp_nxt = rd_pri;
            km_nxt = rd_mem;
            x_nxt  = hi_r[AW-1:0];
            have_nxt = 1'b0;
            state_nxt = S_DNRD;
          end
        endcase
        ck_nxt = {x_nxt, 2'b00} + (CW+3)'(1);
        clast_nxt = {x_nxt, 2'b00} + (CW+3)'(4);
        if ((CW+3)'(fill_m1) < clast_nxt) clast_nxt = (CW+3)'(fill_m1);
      end
      S_UPRD: begin
        if (x_r == '0) begin
          we = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr = (x_r - 1'b1) >> 2;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rd_pri > kp_r) begin
          we = 1'b1;
          wr_pri = rd_pri;
          wr_mem = rd_mem;
          x_nxt  = (x_r - 1'b1) >> 2;
          state_nxt = S_UPRD;
        end else begin
          we = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DNRD: begin
        if (fill_r == '0 || first_c > (CW+3)'(fill_m1)) begin
          we = 1'b1;
          state_nxt = hmode_r ? S_OUT : S_DONE;
        end else begin
          rd_addr = ck_r[AW-1:0];
          state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (!have_r || rd_pri <= bp_r) begin
          bp_nxt = rd_pri;
          bm_nxt = rd_mem;
          best_nxt = ck_r[AW-1:0];
        end
        have_nxt = 1'b1;
        if (ck_r >= clast_r) state_nxt = S_DNMOVE;
        else begin
          ck_nxt = ck_r + 1'b1;
          rd_addr = ck_nxt[AW-1:0];
          state_nxt = S_DNCMP;
        end
      end
      S_DNMOVE: begin
        we = 1'b1;
        have_nxt = 1'b0;
        if (bp_r < kp_r) begin
          wr_pri = bp_r;
          wr_mem = bm_r;
          x_nxt = best_r;
          ck_nxt = {best_r, 2'b00} + (CW+3)'(1);
          clast_nxt = {best_r, 2'b00} + (CW+3)'(4);
          if ((CW+3)'(fill_m1) < clast_nxt) clast_nxt = (CW+3)'(fill_m1);
          state_nxt = S_DNRD;
        end else begin
          state_nxt = hmode_r ? S_OUT : S_DONE;
        end
      end
      S_OUT: begin
        // Heapify step finished: advance to the next lower slot.
        if (hi_r == '0) state_nxt = S_DONE;
        else begin
          hi_nxt = hi_r - 1'b1;
          state_nxt = S_LDRD;
        end
      end
      S_DONE: begin
        if (!out_v_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    res_nxt.entry_count  = 9'(fill_nxt);
    res_nxt.ordered_flag = ord_nxt;
  end

  // Read data is registered: each address is issued by the state before the
  // one that uses the data, and S_DNCMP reads the next child while folding this one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ord_r   <= 1'b1;
      out_v_r <= 1'b0;
      hmode_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ord_r   <= ord_nxt;
      hmode_r <= hmode_nxt;
      if (state_r == S_DONE && !out_v_r) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (state_r != S_DONE) res_r <= res_nxt;
    // Hand the finished result to the output register once it is free.
    if (state_r == S_DONE && !out_v_r) res_hold_r <= res_r;
    x_r     <= x_nxt;
    kp_r    <= kp_nxt;
    km_r    <= km_nxt;
    ck_r    <= ck_nxt;
    clast_r <= clast_nxt;
    best_r  <= best_nxt;
    bp_r    <= bp_nxt;
    bm_r    <= bm_nxt;
    have_r  <= have_nxt;
    lp_r    <= lp_nxt;
    hi_r    <= hi_nxt;
  end

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_ENTRIES)) else $error("fill overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(res_hold_r)) else $error("result lost");
`endif

endmodule

### sim/tb_four_ary_min_heap_queue_top.sv
// Testbench for the four-ary min-heap queue: directed and random operations vs a predictor.
module tb_four_ary_min_heap_queue_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fahq_pkg::*;

  localparam int HEAP_DEPTH = 256;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  fahq_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  fahq_out_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  four_ary_min_heap_queue_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Two-phase clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle percentages for the sender and the receiver; changed per phase.
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  // Results still owed by the block, oldest first.
  fahq_out_t owed_results[$];
  int        mismatch_count = 0;

  // Shadow copy of the heap and its configuration.
  logic [63:0] shadow_pri [HEAP_DEPTH];
  logic [15:0] shadow_tag [HEAP_DEPTH];
  int unsigned shadow_fill = 0;
  bit          shadow_ordered = 1'b1;
  int unsigned shadow_capacity = 256;

  function automatic int unsigned usable_room();
    return (shadow_capacity > HEAP_DEPTH) ? HEAP_DEPTH : shadow_capacity;
  endfunction

  // Climb from slot x while the parent holds a strictly larger priority.
  function automatic void climb(int unsigned x, logic [15:0] tag, logic [63:0] pri);
    int unsigned up;
    while (x > 0) begin
      up = (x - 1) >> 2;
      if (shadow_pri[up] > pri) begin
        shadow_pri[x] = shadow_pri[up];
        shadow_tag[x] = shadow_tag[up];
        x = up;
      end else begin
        break;
      end
    end
    shadow_pri[x] = pri;
    shadow_tag[x] = tag;
  endfunction

  // Smallest child of x, the last one among equal minima; -1 when x is a leaf.
  function automatic int least_child_of(int unsigned x);
    int unsigned first, last;
    int best;
    logic [63:0] best_pri;
    best = -1;
    best_pri = '0;
    first = 4 * x + 1;
    last = 4 * x + 4;
    if (shadow_fill == 0 || first > shadow_fill - 1) return -1;
    if (last > shadow_fill - 1) last = shadow_fill - 1;
    for (int unsigned k = first; k <= last; k++) begin
      if (best < 0 || shadow_pri[k] <= best_pri) begin
        best_pri = shadow_pri[k];
        best = int'(k);
      end
    end
    return best;
  endfunction

  // Sink from slot x while the least child holds a strictly smaller priority.
  function automatic void sink(int unsigned x, logic [15:0] tag, logic [63:0] pri);
    int c;
    forever begin
      c = least_child_of(x);
      if (c < 0) break;
      if (shadow_pri[c] < pri) begin
        shadow_pri[x] = shadow_pri[c];
        shadow_tag[x] = shadow_tag[c];
        x = c;
      end else begin
        break;
      end
    end
    shadow_pri[x] = pri;
    shadow_tag[x] = tag;
  endfunction

  // Apply one operation to the shadow heap and return the result it yields.
  function automatic fahq_out_t apply_operation(fahq_in_t req);
    fahq_out_t   res;
    int unsigned last;
    res = '0;
    res.status = ST_OK;
    case (req.operation)
      OP_INSERT: begin
        if (!shadow_ordered) res.status = ST_UNORD;
        else if (shadow_fill >= usable_room()) res.status = ST_FULL;
        else begin
          shadow_fill++;
          climb(shadow_fill - 1, req.member_tag, req.priority_req);
        end
      end
      OP_APPEND: begin
        if (shadow_fill >= usable_room()) res.status = ST_FULL;
        else begin
          shadow_pri[shadow_fill] = req.priority_req;
          shadow_tag[shadow_fill] = req.member_tag;
          if (shadow_fill != 0) shadow_ordered = 1'b0;
          shadow_fill++;
        end
      end
      OP_HEAPIFY: begin
        for (int unsigned i = shadow_fill; i > 0; i--)
          sink(i - 1, shadow_tag[i - 1], shadow_pri[i - 1]);
        shadow_ordered = 1'b1;
      end
      OP_EXTRACT: begin
        if (!shadow_ordered) res.status = ST_UNORD;
        else if (shadow_fill == 0) res.status = ST_EMPTY;
        else begin
          res.out_member = shadow_tag[0];
          res.out_priority = shadow_pri[0];
          res.out_valid = 1'b1;
          shadow_fill--;
          if (shadow_fill > 0) sink(0, shadow_tag[shadow_fill], shadow_pri[shadow_fill]);
        end
      end
      OP_REMOVE: begin
        if (!shadow_ordered) res.status = ST_UNORD;
        else if (shadow_fill == 0) res.status = ST_EMPTY;
        else if (req.slot_index >= shadow_fill) res.status = ST_BADIDX;
        else begin
          last = shadow_fill - 1;
          shadow_fill = last;
          if (req.slot_index < last) begin
            if (shadow_pri[last] <= shadow_pri[req.slot_index])
              climb(req.slot_index, shadow_tag[last], shadow_pri[last]);
            else
              sink(req.slot_index, shadow_tag[last], shadow_pri[last]);
          end
        end
      end
      OP_UPDATE: begin
        if (req.slot_index >= shadow_fill) res.status = ST_BADIDX;
        else if (!shadow_ordered) res.status = ST_UNORD;
        else if (req.priority_req <= shadow_pri[req.slot_index])
          climb(req.slot_index, shadow_tag[req.slot_index], req.priority_req);
        else
          sink(req.slot_index, shadow_tag[req.slot_index], req.priority_req);
      end
      OP_CLEAR: begin
        shadow_fill = 0;
        shadow_ordered = 1'b1;
      end
      default: ;  // code 7 does nothing
    endcase
    res.entry_count = shadow_fill[8:0];
    res.ordered_flag = shadow_ordered;
    return res;
  endfunction

  // Receiver: check every result transfer, then pick the next ready level.
  always @(posedge clk) begin
    fahq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %h", out_data);
      end else begin
        want = owed_results.pop_front();
        if (out_data.out_member !== want.out_member ||
            out_data.out_priority !== want.out_priority ||
            out_data.out_valid !== want.out_valid ||
            out_data.status !== want.status ||
            out_data.entry_count !== want.entry_count ||
            out_data.ordered_flag !== want.ordered_flag) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: member %h/%h prio %h/%h valid %b/%b ",
                      "status %0d/%0d count %0d/%0d ordered %b/%b (expected/actual)"},
                     want.out_member, out_data.out_member, want.out_priority,
                     out_data.out_priority, want.out_valid, out_data.out_valid,
                     want.status, out_data.status, want.entry_count,
                     out_data.entry_count, want.ordered_flag, out_data.ordered_flag);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Send one operation; hold valid and payload until the transfer happens.
  // Valid is left high on return so back-to-back items need no extra edge.
  task automatic push_op(logic [2:0] op, logic [15:0] tag, logic [63:0] pri,
                         logic [7:0] slot);
    fahq_in_t req;
    req.operation = op;
    req.member_tag = tag;
    req.priority_req = pri;
    req.slot_index = slot;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    owed_results.push_back(apply_operation(req));
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write capacity_limit while the queue is idle: setup then access cycle.
  task automatic write_capacity(int unsigned value);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(4 * REG_CAPACITY);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    shadow_capacity = value & 9'h1FF;
  endtask

  // Directed corners: empty, extremes, ties, unordered refusals, code 7.
  task automatic test_directed_ops();
    push_op(OP_EXTRACT, 16'h0000, 64'd0, 8'd0);            // empty extract
    push_op(OP_REMOVE, 16'h0000, 64'd0, 8'd0);             // empty remove
    push_op(OP_UPDATE, 16'hFFFF, 64'd5, 8'd0);             // bad slot on empty
    push_op(OP_INSERT, 16'hFFFF, '1, 8'hFF);               // largest priority
    push_op(OP_INSERT, 16'h0000, 64'd0, 8'h00);            // smallest priority
    push_op(OP_INSERT, 16'h1111, 64'd7, 8'd0);
    push_op(OP_INSERT, 16'h2222, 64'd7, 8'd0);             // equal children
    push_op(OP_INSERT, 16'h3333, 64'd7, 8'd0);
    push_op(OP_INSERT, 16'h4444, 64'd7, 8'd0);
    push_op(OP_EXTRACT, 16'h0, 64'd0, 8'd0);               // tie pick on sift-down
    push_op(OP_UPDATE, 16'h0, 64'd1, 8'd3);                // update climbs
    push_op(OP_UPDATE, 16'h0, 64'h8000_0000_0000_0000, 8'd0); // update sinks
    push_op(OP_UPDATE, 16'h0, 64'd3, 8'd200);              // bad slot
    push_op(OP_APPEND, 16'hABCD, 64'd2, 8'd0);             // clears ordered flag
    push_op(OP_UPDATE, 16'h0, 64'd3, 8'd200);              // bad slot wins over unordered
    push_op(OP_UPDATE, 16'h0, 64'd3, 8'd0);                // unordered
    push_op(OP_INSERT, 16'h5555, 64'd9, 8'd0);             // unordered
    push_op(OP_EXTRACT, 16'h0, 64'd0, 8'd0);               // unordered
    push_op(OP_REMOVE, 16'h0, 64'd0, 8'd0);                // unordered
    push_op(3'd7, 16'hFFFF, '1, 8'hFF);                    // unused code
    push_op(OP_HEAPIFY, 16'h0, 64'd0, 8'd0);
    push_op(OP_REMOVE, 16'h0, 64'd0, 8'd1);
    push_op(OP_REMOVE, 16'h0, 64'd0, 8'd250);              // bad slot
    push_op(OP_EXTRACT, 16'h0, 64'd0, 8'd0);
    push_op(OP_CLEAR, 16'h0, 64'd0, 8'd0);
  endtask

  // Small capacities, zero capacity and a full store with the top slot in use.
  task automatic test_capacity_limits();
    write_capacity(1);
    push_op(OP_INSERT, 16'h0101, 64'd10, 8'd0);
    push_op(OP_INSERT, 16'h0102, 64'd1, 8'd0);             // full
    push_op(OP_APPEND, 16'h0103, 64'd1, 8'd0);             // full
    push_op(OP_CLEAR, 16'h0, 64'd0, 8'd0);
    write_capacity(0);
    push_op(OP_INSERT, 16'h0201, 64'd1, 8'd0);
    push_op(OP_APPEND, 16'h0202, 64'd1, 8'd0);
    write_capacity(511);                                   // acts as the store size
    for (int i = 0; i < HEAP_DEPTH; i++)
      push_op(OP_APPEND, 16'($urandom), 64'($urandom_range(40)), 8'd0);
    push_op(OP_APPEND, 16'h0, 64'd0, 8'd0);                // full
    push_op(OP_HEAPIFY, 16'h0, 64'd0, 8'd0);
    push_op(OP_INSERT, 16'h0, 64'd0, 8'd0);                // full
    push_op(OP_UPDATE, 16'h0, 64'd0, 8'd255);
    push_op(OP_REMOVE, 16'h0, 64'd0, 8'd255);
    push_op(OP_REMOVE, 16'h0, 64'd0, 8'd17);
    for (int i = 0; i < 12; i++) push_op(OP_EXTRACT, 16'h0, 64'd0, 8'd0);
    push_op(OP_CLEAR, 16'h0, 64'd0, 8'd0);
  endtask

  // Random operations biased toward well-formed heap traffic.
  task automatic test_random_traffic(int items);
    int          pick;
    logic [2:0]  op;
    logic [63:0] pri;
    logic [7:0]  slot;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (!shadow_ordered && pick < 60) op = OP_HEAPIFY;
      else if (pick < 35) op = OP_INSERT;
      else if (pick < 55) op = OP_EXTRACT;
      else if (pick < 68) op = OP_UPDATE;
      else if (pick < 80) op = OP_REMOVE;
      else if (pick < 90) op = OP_APPEND;
      else if (pick < 94) op = OP_HEAPIFY;
      else if (pick < 97) op = OP_CLEAR;
      else op = 3'($urandom);
      // Narrow priorities give ties; wide ones reach the upper bits.
      if ($urandom_range(3) == 0) pri = {$urandom, $urandom};
      else pri = 64'($urandom_range(31));
      if (shadow_fill > 0 && $urandom_range(7) != 0)
        slot = 8'($urandom_range(shadow_fill - 1));
      else slot = 8'($urandom);
      push_op(op, 16'($urandom), pri, slot);
    end
  endtask

  // Run limit.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_capacity_limits();

    // Phase 1: sender idles lightly, receiver stalls often.
    write_capacity(256);
    sender_idle_pct = 24;
    receiver_idle_pct = 62;
    test_random_traffic(150);
    drain();                                               // full pause
    // Phase 2: the other way round, with a small heap.
    write_capacity(17);
    sender_idle_pct = 62;
    receiver_idle_pct = 24;
    test_random_traffic(150);
    // Phase 3: no idling, largest capacity setting.
    write_capacity(511);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_traffic(150);

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
